FILE: hw/rtl/dbto_pkg.sv
// shared types and constants for the graph store and topological sort
package dbto_pkg;
    localparam int NodeIdW  = 4;
    localparam int IdSpace  = 16;
    localparam int CntW     = 5;
    localparam int MaxNodes = 16;
    localparam int Capacity = (MaxNodes > IdSpace) ? IdSpace : MaxNodes;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_EDGE  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SELF     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EXISTS   = 3'd3;
    localparam logic [2:0] ST_WCYCLE   = 3'd4;
    localparam logic [2:0] ST_GCYCLE   = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    typedef logic [IdSpace-1:0] t_row;

    typedef struct packed {
        logic              start;
        logic [NodeIdW:0]  count;
    } t_sort_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [NodeIdW:0]  placed;
    } t_sort_rsp;
endpackage

FILE: hw/rtl/dbto_sorter.sv
// kahn sort sequencer: one shared decrement/compare unit steps over ids
module dbto_sorter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dbto_pkg::t_sort_req           i_req,
    input  dbto_pkg::t_row                i_adj [dbto_pkg::IdSpace],
    input  logic [dbto_pkg::NodeIdW-1:0]  i_ins [dbto_pkg::IdSpace],
    input  logic [dbto_pkg::NodeIdW-1:0]  i_rd_idx,
    output logic [dbto_pkg::NodeIdW-1:0]  o_rd_node,
    output dbto_pkg::t_sort_rsp           o_rsp
);
    import dbto_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CNT   = 6'b000010,
        S_SEED  = 6'b000100,
        S_FETCH = 6'b001000,
        S_PROC  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [CntW-1:0]       r_indeg [IdSpace];
    logic [NodeIdW-1:0]    r_fifo  [IdSpace];
    logic [NodeIdW-1:0]    r_i, r_s;
    logic [NodeIdW:0]      r_head, r_tail, r_cnt;
    logic [NodeIdW-1:0]    r_cur;

    // shared unit operand
    logic [CntW-1:0]       w_deg, w_dec;
    logic                  w_bit, w_push, w_tail_ok;
    logic [NodeIdW-1:0]    w_seed;

    assign w_seed    = i_ins[r_i];
    assign w_deg     = (r_state == S_SEED) ? r_indeg[w_seed] : r_indeg[r_s];
    assign w_dec     = (w_deg != '0) ? w_deg - 1'b1 : w_deg;
    assign w_tail_ok = r_tail < (NodeIdW+1)'(IdSpace);
    assign w_bit     = (r_state == S_CNT) ? i_adj[r_i][r_s] : i_adj[r_cur][r_s];
    assign w_push    = (r_state == S_SEED) ? (w_deg == '0) : (w_bit && w_dec == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req.start) n_state = S_CNT;
            S_CNT:   if (r_i == '1 && r_s == '1) n_state = S_SEED;
            S_SEED:  if ({1'b0, r_i} + 1'b1 >= r_cnt) n_state = S_FETCH;
            S_FETCH: n_state = (r_head == r_tail) ? S_DONE : S_PROC;
            S_PROC:  if (r_s == '1) n_state = S_FETCH;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i <= '0; r_s <= '0; r_head <= '0; r_tail <= '0; r_cnt <= '0; r_cur <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_req.start) begin
                    r_i <= '0; r_s <= '0; r_head <= '0; r_tail <= '0;
                    r_cnt <= i_req.count;
                    for (int k = 0; k < IdSpace; k++) r_indeg[k] <= '0;
                end
                S_CNT: begin
                    if (w_bit) r_indeg[r_s] <= r_indeg[r_s] + 1'b1;
                    r_s <= r_s + 1'b1;
                    if (r_s == '1) r_i <= r_i + 1'b1;
                end
                S_SEED: begin
                    if (r_cnt != '0) begin
                        if (w_push && w_tail_ok) begin
                            r_fifo[r_tail[NodeIdW-1:0]] <= w_seed;
                            r_tail <= r_tail + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_FETCH: begin
                    // take the next ready node and restart the row scan
                    if (r_head != r_tail) begin
                        r_cur  <= r_fifo[r_head[NodeIdW-1:0]];
                        r_head <= r_head + 1'b1;
                        r_s    <= '0;
                    end
                end
                S_PROC: begin
                    if (w_bit) begin
                        r_indeg[r_s] <= w_dec;
                        if (w_dec == '0 && w_tail_ok) begin
                            r_fifo[r_tail[NodeIdW-1:0]] <= r_s;
                            r_tail <= r_tail + 1'b1;
                        end
                    end
                    r_s <= r_s + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_rd_node  = r_fifo[i_rd_idx];
    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.placed = r_tail;
endmodule

FILE: hw/rtl/dag_builder_topological_order_top.sv
// top level of the graph store with kahn topological ordering
//
// channel | dir | fields
// s_axis  | in  | tdata: func[1:0] node_a[5:2] node_b[9:6]
// m_axis  | out | tdata: status[2:0] order_node[6:3] order_valid[7]; tlast: last
//
// add node and rejected connects: the result register loads on the accepting edge.
// connect and query: one sort pass in the shared sorter, made of indegree counting,
// seeding, then fetch and relaxation of each ready node; a query then streams one
// result a cycle while the output is not stalled.
// reset clears present bits, adjacency and node count; the insertion list is
// not cleared. output stalls hold the result register; input waits meanwhile.
module dag_builder_topological_order_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // func, node_a, node_b from bit 0
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // status, order_node, order_valid from bit 0
    output logic        m_axis_tlast
);
    import dbto_pkg::*;

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_SORT = 5'b00010,
        T_WAIT = 5'b00100,
        T_OUT  = 5'b01000,
        T_EMIT = 5'b10000
    } t_tstate;

    t_tstate             r_state;
    logic [IdSpace-1:0]  r_present;
    t_row                r_adj [IdSpace];
    logic [NodeIdW-1:0]  r_ins [IdSpace];
    logic [NodeIdW:0]    r_count;
    logic [1:0]          r_func;
    logic [NodeIdW-1:0]  r_a, r_b;
    logic [NodeIdW:0]    r_k;
    logic [2:0]          r_st;
    logic [NodeIdW-1:0]  r_node;
    logic                r_ov, r_last, r_mvalid;

    t_sort_req           w_req;
    t_sort_rsp           w_rsp;
    logic [NodeIdW-1:0]  w_rd_node;
    logic                w_acc;
    logic [1:0]          w_func;
    logic [NodeIdW-1:0]  w_a, w_b;

    assign w_func = s_axis_tdata[1:0];
    assign w_a    = s_axis_tdata[5:2];
    assign w_b    = s_axis_tdata[9:6];
    assign s_axis_tready = (r_state == T_IDLE) && !r_mvalid;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    assign w_req.start = (r_state == T_SORT);
    assign w_req.count = r_count;

    dbto_sorter u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_adj     (r_adj),
        .i_ins     (r_ins),
        .i_rd_idx  (r_k[NodeIdW-1:0]),
        .o_rd_node (w_rd_node),
        .o_rsp     (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_present <= '0;
            r_count  <= '0;
            r_mvalid <= 1'b0;
            r_k      <= '0;
            for (int k = 0; k < IdSpace; k++) r_adj[k] <= '0;
        end else begin
            // while streaming the order the output register is handled below
            if (r_mvalid && m_axis_tready && r_state != T_OUT) r_mvalid <= 1'b0;
            case (r_state)
                T_IDLE: if (w_acc) begin
                    r_func <= w_func; r_a <= w_a; r_b <= w_b;
                    r_node <= '0; r_ov <= 1'b0; r_last <= 1'b1;
                    case (w_func)
                        FUNC_ADD: begin
                            r_mvalid <= 1'b1;
                            if (r_present[w_a]) r_st <= ST_EXISTS;
                            else if (r_count >= (NodeIdW+1)'(Capacity)) r_st <= ST_FULL;
                            else begin
                                r_present[w_a] <= 1'b1;
                                r_ins[r_count[NodeIdW-1:0]] <= w_a;
                                r_count <= r_count + 1'b1;
                                r_st <= ST_OK;
                            end
                        end
                        FUNC_EDGE: begin
                            if (!r_present[w_a] || !r_present[w_b]) begin
                                r_st <= ST_NOTFOUND; r_mvalid <= 1'b1;
                            end else if (w_a == w_b) begin
                                r_st <= ST_SELF; r_mvalid <= 1'b1;
                            end else if (r_adj[w_a][w_b]) begin
                                r_st <= ST_EXISTS; r_mvalid <= 1'b1;
                            end else begin
                                // tentative edge, withdrawn on cycle
                                r_adj[w_a][w_b] <= 1'b1;
                                r_state <= T_SORT;
                            end
                        end
                        FUNC_QUERY: r_state <= T_SORT;
                        default: ;
                    endcase
                end
                T_SORT: r_state <= T_WAIT;
                T_WAIT: if (w_rsp.done) begin
                    if (r_func == FUNC_EDGE) begin
                        if (w_rsp.placed != r_count) begin
                            r_adj[r_a][r_b] <= 1'b0;
                            r_st <= ST_WCYCLE;
                        end else r_st <= ST_OK;
                        r_mvalid <= 1'b1;
                        r_state  <= T_IDLE;
                    end else if (w_rsp.placed != r_count) begin
                        r_st <= ST_GCYCLE; r_mvalid <= 1'b1; r_state <= T_IDLE;
                    end else if (r_count == '0) begin
                        r_st <= ST_OK; r_mvalid <= 1'b1; r_state <= T_IDLE;
                    end else begin
                        r_k <= '0;
                        r_state <= T_OUT;
                    end
                end
                T_OUT: if (!r_mvalid || m_axis_tready) begin
                    // stream one order element each time the output register is free or taken
                    r_st <= ST_OK; r_node <= w_rd_node; r_ov <= 1'b1;
                    r_last <= (r_k + 1'b1 == r_count);
                    r_mvalid <= 1'b1;
                    r_k <= r_k + 1'b1;
                    if (r_k + 1'b1 == r_count) r_state <= T_EMIT;
                end
                T_EMIT: if (!r_mvalid || m_axis_tready) r_state <= T_IDLE;
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {r_ov, r_node, r_st};
    assign m_axis_tlast  = r_last;

`ifndef ASSERT_OFF
    a_no_take_while_sorting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.busy |-> !s_axis_tready) else $error("input taken during sort");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (NodeIdW+1)'(Capacity)) else $error("node count overflow");
    a_order_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_ov) |-> (r_st == ST_OK)) else $error("bad order status");
`endif
endmodule
